FILE: rtl/core/prim_mst_over_room_centers_defines.svh
// Assertion macros for the checker file of the room tree block.
`ifndef PRIM_MST_OVER_ROOM_CENTERS_DEFINES_SVH
`define PRIM_MST_OVER_ROOM_CENTERS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PMST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmst check failed: same cycle implication");

// Next-cycle implication, checked outside reset.
`define PMST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmst check failed: next cycle implication");

`endif

FILE: rtl/core/pmst_pkg.sv
// Package with sizes shared by the room tree block.
package pmst_pkg;
    localparam int ROOM_SLOTS  = 16;
    localparam int ROOM_BITS   = 4;
    localparam int COUNT_BITS  = 5;
    localparam int COORD_BITS  = 8;
    localparam int CENTER_BITS = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * CENTER_BITS;
    localparam int WEIGHT_BITS = SQ_BITS + 8;
    localparam int ENTRY_BITS  = 2 * CENTER_BITS;
endpackage

FILE: rtl/core/pmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/prim_mst_over_room_centers.sv
// Prim spanning tree over room centers: loads rooms, then emits tree edges.
//
// Input channel (in_valid / in_stall): one word per room, origin and size.
// Rooms load at one word per cycle. The word with last_room set closes the
// set and starts the tree run; in_stall stays high until the run is done.
// Rooms beyond sixteen are dropped; a root not below the count means room 0.
//
// Output channel (out_valid / out_stall): one word per tree round, n-1
// words for n rooms, or a single word with edge_valid low for one room.
// last_edge marks the final word, whose added_room is the stairs room.
//
// Each round walks all pairs i<j of the stored rooms through one
// shared square-and-compare unit. A crossing pair passes the read, square
// and compare states, a pair that does not cross only the read state, and
// each round ends with an emit state.
// The output word sits in a register; if the receiver stalls, the block
// holds at the end of the next round until the word is taken.
// Reset clears the room count, tree flags and output valid; the stored
// centers are not cleared and are only read after being written.
module prim_mst_over_room_centers
    import pmst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] room_x,
    input  logic [COORD_BITS-1:0] room_y,
    input  logic [COORD_BITS-1:0] room_width,
    input  logic [COORD_BITS-1:0] room_height,
    input  logic [ROOM_BITS-1:0]  root_room,
    input  logic                  last_room,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROOM_BITS-1:0]  edge_room_low,
    output logic [ROOM_BITS-1:0]  edge_room_high,
    output logic [ROOM_BITS-1:0]  added_room,
    output logic                  edge_valid,
    output logic                  last_edge
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [COUNT_BITS-1:0]  loaded_reg, loaded_next;
    logic [COUNT_BITS-1:0]  n_reg, n_next;
    logic [COUNT_BITS-1:0]  round_reg, round_next;
    logic [ROOM_BITS-1:0]   i_reg, i_next, j_reg, j_next;
    logic [ROOM_SLOTS-1:0]  tree_reg, tree_next;
    logic                   single_reg, single_next;
    logic                   found_reg, found_next;
    logic [WEIGHT_BITS-1:0] best_w_reg, best_w_next;
    logic [ROOM_BITS-1:0]   best_i_reg, best_i_next, best_j_reg, best_j_next;
    logic [ROOM_BITS-1:0]   root_reg, root_next;
    logic [SQ_BITS-1:0]     sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic                   ov_reg, ov_next;
    logic [ROOM_BITS-1:0]   lo_reg, lo_next, hi_reg, hi_next, add_reg, add_next;
    logic                   ev_reg, ev_next, le_reg, le_next;

    logic                   in_acc;
    logic                   store_room;
    logic [COORD_BITS-1:0]  half_w, half_h;
    logic [CENTER_BITS-1:0] ctr_col, ctr_row;
    logic [ENTRY_BITS-1:0]  ent_i, ent_j;
    logic [CENTER_BITS-1:0] dx, dy;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   pair_last;
    logic [ROOM_BITS-1:0]   j_step;
    logic [COUNT_BITS-1:0]  n_load;
    logic [ROOM_BITS-1:0]   added;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Center of the incoming room, one bit wider than the origin.
    assign half_w  = (room_width == '0) ? '0 : (room_width - 1'b1) >> 1;
    assign half_h  = (room_height == '0) ? '0 : (room_height - 1'b1) >> 1;
    assign ctr_col = {1'b0, room_x} + {1'b0, half_w};
    assign ctr_row = {1'b0, room_y} + {1'b0, half_h};
    assign store_room = in_acc && (loaded_reg < COUNT_BITS'(ROOM_SLOTS));
    assign n_load = store_room ? loaded_reg + 1'b1 : loaded_reg;

    // Two copies of the center store give one read port per pair member.
    pmst_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ROOM_SLOTS)) u_ram_i (
        .clk   (clk),
        .we    (store_room),
        .waddr (loaded_reg[ROOM_BITS-1:0]),
        .wdata ({ctr_col, ctr_row}),
        .raddr (i_reg),
        .rdata (ent_i)
    );

    pmst_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ROOM_SLOTS)) u_ram_j (
        .clk   (clk),
        .we    (store_room),
        .waddr (loaded_reg[ROOM_BITS-1:0]),
        .wdata ({ctr_col, ctr_row}),
        .raddr (j_reg),
        .rdata (ent_j)
    );

    // Absolute differences of the pair's centers.
    assign dx = (ent_i[ENTRY_BITS-1:CENTER_BITS] >= ent_j[ENTRY_BITS-1:CENTER_BITS])
              ? ent_i[ENTRY_BITS-1:CENTER_BITS] - ent_j[ENTRY_BITS-1:CENTER_BITS]
              : ent_j[ENTRY_BITS-1:CENTER_BITS] - ent_i[ENTRY_BITS-1:CENTER_BITS];
    assign dy = (ent_i[CENTER_BITS-1:0] >= ent_j[CENTER_BITS-1:0])
              ? ent_i[CENTER_BITS-1:0] - ent_j[CENTER_BITS-1:0]
              : ent_j[CENTER_BITS-1:0] - ent_i[CENTER_BITS-1:0];

    // Weight 49*dx^2 + 256*dy^2 from the registered squares.
    assign weight = (WEIGHT_BITS'(sqx_reg) << 5) + (WEIGHT_BITS'(sqx_reg) << 4)
                  + WEIGHT_BITS'(sqx_reg) + (WEIGHT_BITS'(sqy_reg) << 8);

    // Pair walk: j runs up to n-1, then i steps and j restarts at i+1.
    assign pair_last = ({1'b0, i_reg} == n_reg - 2'd2) && ({1'b0, j_reg} == n_reg - 1'b1);
    assign j_step    = i_reg + 2'd2;
    assign added     = tree_reg[best_i_reg] ? best_j_reg : best_i_reg;

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        n_next      = n_reg;
        round_next  = round_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        tree_next   = tree_reg;
        single_next = single_reg;
        found_next  = found_reg;
        best_w_next = best_w_reg;
        best_i_next = best_i_reg;
        best_j_next = best_j_reg;
        root_next   = root_reg;
        sqx_next    = sqx_reg;
        sqy_next    = sqy_reg;
        ov_next     = ov_reg && out_stall;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        add_next    = add_reg;
        ev_next     = ev_reg;
        le_next     = le_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    loaded_next = n_load;
                    if (last_room)
                    begin
                        loaded_next = '0;
                        n_next      = n_load;
                        root_next   = ({1'b0, root_room} < n_load) ? root_room : '0;
                        tree_next   = '0;
                        tree_next[root_next] = 1'b1;
                        single_next = (n_load <= COUNT_BITS'(1));
                        round_next  = COUNT_BITS'(1);
                        found_next  = 1'b0;
                        i_next      = '0;
                        j_next      = ROOM_BITS'(1);
                        state_next  = (n_load <= COUNT_BITS'(1)) ? ST_EMIT : ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                // Only crossing pairs go through the square unit.
                if (tree_reg[i_reg] != tree_reg[j_reg])
                begin
                    state_next = ST_SQ;
                end
                else if (pair_last)
                begin
                    state_next = ST_EMIT;
                end
                else if ({1'b0, j_reg} == n_reg - 1'b1)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = j_step;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                sqx_next   = dx * dx;
                sqy_next   = dy * dy;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // Strict less keeps the earliest pair on a tie.
                if (!found_reg || weight < best_w_reg)
                begin
                    found_next  = 1'b1;
                    best_w_next = weight;
                    best_i_next = i_reg;
                    best_j_next = j_reg;
                end
                if (pair_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_RD;
                    if ({1'b0, j_reg} == n_reg - 1'b1)
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = j_step;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                // Load the output word once the previous one is gone.
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    if (single_reg)
                    begin
                        lo_next    = '0;
                        hi_next    = '0;
                        add_next   = root_reg;
                        ev_next    = 1'b0;
                        le_next    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lo_next    = best_i_reg;
                        hi_next    = best_j_reg;
                        add_next   = added;
                        ev_next    = 1'b1;
                        le_next    = (round_reg == n_reg - 1'b1);
                        tree_next[added] = 1'b1;
                        round_next = round_reg + 1'b1;
                        found_next = 1'b0;
                        i_next     = '0;
                        j_next     = ROOM_BITS'(1);
                        state_next = (round_reg == n_reg - 1'b1) ? ST_IDLE : ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
            tree_reg   <= '0;
            ov_reg     <= 1'b0;
            found_reg  <= 1'b0;
            single_reg <= 1'b0;
            round_reg  <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            tree_reg   <= tree_next;
            ov_reg     <= ov_next;
            found_reg  <= found_next;
            single_reg <= single_next;
            round_reg  <= round_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
        end
    end

    // Datapath and output word.
    always_ff @(posedge clk)
    begin
        best_w_reg <= best_w_next;
        best_i_reg <= best_i_next;
        best_j_reg <= best_j_next;
        root_reg   <= root_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        add_reg    <= add_next;
        ev_reg     <= ev_next;
        le_reg     <= le_next;
    end

    assign out_valid      = ov_reg;
    assign edge_room_low  = lo_reg;
    assign edge_room_high = hi_reg;
    assign added_room     = add_reg;
    assign edge_valid     = ev_reg;
    assign last_edge      = le_reg;
endmodule

FILE: rtl/core/pmst_checker.sv
// Port checker for the room tree block and its bind.
`include "prim_mst_over_room_centers_defines.svh"

module pmst_checker
    import pmst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [ROOM_BITS-1:0] edge_room_low,
    input logic [ROOM_BITS-1:0] edge_room_high,
    input logic [ROOM_BITS-1:0] added_room,
    input logic                 edge_valid,
    input logic                 last_edge
);
    // A stalled word stays put.
    `PMST_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(added_room) && $stable(last_edge))
    // A word without an edge only comes from a one-room set, so it is final.
    `PMST_ASSERT_NOW(a_single, out_valid && !edge_valid, last_edge)
    // Edges are reported with the lower index first.
    `PMST_ASSERT_NOW(a_order, out_valid && edge_valid, edge_room_low < edge_room_high)
    // The added room is one end of the reported edge.
    `PMST_ASSERT_NOW(a_end, out_valid && edge_valid, added_room == edge_room_low || added_room == edge_room_high)
endmodule

bind prim_mst_over_room_centers pmst_checker u_pmst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_room_low  (edge_room_low),
    .edge_room_high (edge_room_high),
    .added_room     (added_room),
    .edge_valid     (edge_valid),
    .last_edge      (last_edge)
);

FILE: tb/testbench.sv
// Testbench for the room spanning tree block: directed and random room sets checked against a Prim predictor.
module testbench;
    import pmst_pkg::*;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic [3:0] root;
        logic       last;
    } room_word_t;

    typedef struct packed {
        logic [3:0] lo;
        logic [3:0] hi;
        logic [3:0] added;
        logic       valid;
        logic       last;
    } tree_edge_t;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] room_x, room_y, room_width, room_height;
    logic [3:0] root_room;
    logic last_room;
    logic out_valid;
    logic out_stall;
    logic [3:0] edge_room_low, edge_room_high, added_room;
    logic edge_valid, last_edge;

    room_word_t room_queue[$];
    tree_edge_t tree_edges_due[$];
    int fail_count;
    int edges_seen;
    int sets_sent;
    int idle_cycles;
    int gap_left;
    int burst_left;
    bit hold_for_drain;
    bit all_sent;
    bit in_taken;

    // Predictor state.
    logic [8:0] pred_col[ROOM_SLOTS];
    logic [8:0] pred_row[ROOM_SLOTS];
    int pred_count;

    prim_mst_over_room_centers u_dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Store the room and, on the closing word, grow the tree and queue its edges.
    task automatic predict_tree(input room_word_t rw);
        int n;
        int root;
        int bi;
        int bj;
        int added;
        bit found;
        bit member[ROOM_SLOTS];
        longint best;
        longint wgt;
        longint dx;
        longint dy;
        tree_edge_t te;
        if (pred_count < ROOM_SLOTS)
        begin
            pred_col[pred_count] = rw.x + ((rw.w == 0) ? 0 : (rw.w - 1) >> 1);
            pred_row[pred_count] = rw.y + ((rw.h == 0) ? 0 : (rw.h - 1) >> 1);
            pred_count++;
        end
        if (!rw.last)
            return;
        n = pred_count;
        pred_count = 0;
        root = (rw.root >= n) ? 0 : rw.root;
        foreach (member[k])
            member[k] = 1'b0;
        member[root] = 1'b1;
        if (n <= 1)
        begin
            te = '{lo: 4'd0, hi: 4'd0, added: root[3:0], valid: 1'b0, last: 1'b1};
            tree_edges_due.push_back(te);
            return;
        end
        for (int r = 1; r < n; r++)
        begin
            found = 1'b0;
            best = 0;
            bi = 0;
            bj = 0;
            for (int i = 0; i + 1 < n; i++)
                for (int j = i + 1; j < n; j++)
                begin
                    if (member[i] == member[j])
                        continue;
                    dx = (pred_col[i] >= pred_col[j]) ? pred_col[i] - pred_col[j]
                                                      : pred_col[j] - pred_col[i];
                    dy = (pred_row[i] >= pred_row[j]) ? pred_row[i] - pred_row[j]
                                                      : pred_row[j] - pred_row[i];
                    wgt = 49 * dx * dx + 256 * dy * dy;
                    if (!found || wgt < best)
                    begin
                        found = 1'b1;
                        best = wgt;
                        bi = i;
                        bj = j;
                    end
                end
            added = member[bi] ? bj : bi;
            member[added] = 1'b1;
            te = '{lo: bi[3:0], hi: bj[3:0], added: added[3:0], valid: 1'b1,
                   last: (r + 1 == n)};
            tree_edges_due.push_back(te);
        end
    endtask

    function automatic room_word_t random_room(input bit closing);
        room_word_t rw;
        rw.x = $urandom_range(0, 255);
        rw.y = $urandom_range(0, 255);
        rw.w = $urandom_range(1, 255);
        rw.h = $urandom_range(1, 255);
        rw.root = $urandom_range(0, 15);
        rw.last = closing;
        return rw;
    endfunction

    task automatic queue_set(input int n, input bit tight);
        room_word_t rw;
        for (int k = 0; k < n; k++)
        begin
            rw = random_room(k == n - 1);
            // Clustered centers give many equal weights.
            if (tight)
            begin
                rw.x = $urandom_range(0, 3);
                rw.y = $urandom_range(0, 3);
                rw.w = 1;
                rw.h = 1;
            end
            room_queue.push_back(rw);
        end
    endtask

    // Stimulus: directed sets first, then random sets, mostly small.
    initial
    begin
        room_word_t rw;
        int n;
        rw = '{x: 8'd255, y: 8'd255, w: 8'd255, h: 8'd255, root: 4'd15, last: 1'b1};
        room_queue.push_back(rw);                       // single room, root out of range
        rw = '{x: 8'd0, y: 8'd0, w: 8'd1, h: 8'd1, root: 4'd0, last: 1'b0};
        room_queue.push_back(rw);
        rw = '{x: 8'd255, y: 8'd255, w: 8'd255, h: 8'd255, root: 4'd1, last: 1'b1};
        room_queue.push_back(rw);                       // farthest pair
        // Full store plus two dropped rooms, the closing one among them.
        for (int k = 0; k < 18; k++)
        begin
            rw = random_room(k == 17);
            rw.root = 4'd15;
            room_queue.push_back(rw);
        end
        queue_set(4, 1'b1);                             // ties
        while (room_queue.size() < 160)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 6);
            queue_set(n, $urandom_range(0, 3) == 0);
        end
    end

    // Record at each rising edge whether the input word was taken.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // Driver: bursts with random gaps; from one set on, it holds each word until the tree edges drain.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {room_x, room_y, room_width, room_height, root_room, last_room} <= '0;
            gap_left <= 0;
            burst_left <= 0;
            hold_for_drain <= 1'b0;
            all_sent <= 1'b0;
            sets_sent <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_valid && last_room)
                sets_sent <= sets_sent + 1;
            if (room_queue.size() == 0)
            begin
                in_valid <= 1'b0;
                all_sent <= 1'b1;
            end
            else if (in_valid && last_room && sets_sent == 5 && !hold_for_drain)
            begin
                hold_for_drain <= 1'b1;
                in_valid <= 1'b0;
            end
            else if (hold_for_drain && tree_edges_due.size() != 0)
                in_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                {room_x, room_y, room_width, room_height, root_room, last_room}
                    <= room_queue.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver stall pattern: stretches of free flow and of random stalls.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (($time / 2000) % 3 == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 40);
    end

    // Monitor: predict on accepted rooms, check accepted edges.
    always @(posedge clk)
    begin
        tree_edge_t got;
        tree_edge_t want;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                predict_tree({room_x, room_y, room_width, room_height, root_room, last_room});
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                edges_seen <= edges_seen + 1;
                got = {edge_room_low, edge_room_high, added_room, edge_valid, last_edge};
                if (tree_edges_due.size() == 0)
                begin
                    $display("%0t: unexpected edge word %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = tree_edges_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: edge mismatch expected lo=%0d hi=%0d added=%0d valid=%0b last=%0b",
                                 $time, want.lo, want.hi, want.added, want.valid, want.last);
                        $display("%0t:                  actual lo=%0d hi=%0d added=%0d valid=%0b last=%0b",
                                 $time, got.lo, got.hi, got.added, got.valid, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        fail_count = 0;
        edges_seen = 0;
        idle_cycles = 0;
        pred_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;
        wait (all_sent && tree_edges_due.size() == 0);
        repeat (50) @(posedge clk);
        $display("Ran %0d room sets, checked %0d tree edge words.", sets_sent, edges_seen);
        if (fail_count == 0 && tree_edges_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pmst_pkg.sv
rtl/core/pmst_ram.sv
rtl/core/prim_mst_over_room_centers.sv
rtl/core/pmst_checker.sv
tb/testbench.sv
